/* rtl/afr_pkg.sv */
package afr_pkg;

  // Ring and staging chunk sizes.
  localparam int BUFFER_FRAMES = 4096;
  localparam int CHUNK_FRAMES  = 64;

  localparam int PTR_W   = (BUFFER_FRAMES > 1) ? $clog2(BUFFER_FRAMES) : 1;
  localparam int CHUNK_W = (CHUNK_FRAMES > 1) ? $clog2(CHUNK_FRAMES) : 1;
  localparam int COPY_W  = $clog2(CHUNK_FRAMES + 1);

  // Field widths.
  localparam int SAMPLE_W = 20;
  localparam int OUT_W    = 16;
  localparam int VOL_W    = 7;
  localparam int FILL_W   = 12;
  localparam int FRAME_W  = 2 * SAMPLE_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCARD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE   = 2'd2;

  localparam logic [VOL_W-1:0] VOLUME_RESET = 7'd100;

  // Request codes.
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_FLUSH = 2'd2;

  typedef struct packed {
    logic [1:0]                 req_type;
    logic signed [SAMPLE_W-1:0] in_left;
    logic signed [SAMPLE_W-1:0] in_right;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] out_left;
    logic signed [OUT_W-1:0] out_right;
    logic                    from_buffer;
    logic [FILL_W-1:0]       fill_level;
  } out_item_t;

endpackage

/* rtl/audio_frame_ring_with_volume_top.sv */
// Channel   Handshake                     Payload
// in        in_valid / in_ready           in_data   (req_type, in_left, in_right)
// out       out_valid / out_ready         out_data  (out_left, out_right,
//                                                    from_buffer, fill_level)
// cfg       cfg_we (no wait)              cfg_index, cfg_data
//
// A write that completes the chunk copies CHUNK_FRAMES frames through the single ring
// write port when it fits and discard is off. A read that pops goes through ring read,
// volume multiply, reciprocal divide and result load; a zero-fill read skips to the
// result load. Reset is synchronous and resets pointers, counts and control registers,
// not the memories. Input is accepted only when idle; a finished result waits in the
// output register, and a read behind it stalls until it is taken.
module audio_frame_ring_with_volume_top import afr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_COPY,
    S_FETCH,
    S_MUL,
    S_OUT
  } state_t;

  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(BUFFER_FRAMES - 1);
  localparam logic [PTR_W-1:0] PUSH_MAX  = PTR_W'(BUFFER_FRAMES - CHUNK_FRAMES);
  localparam logic [CHUNK_W-1:0] CHUNK_LAST = CHUNK_W'(CHUNK_FRAMES - 1);
  localparam logic [COPY_W-1:0] COPY_END = COPY_W'(CHUNK_FRAMES);

  state_t             state;
  logic [VOL_W-1:0]   volume;
  logic               discard;
  logic               pause;
  logic [CHUNK_W-1:0] staging_count;
  logic [PTR_W-1:0]   read_ptr;
  logic [PTR_W-1:0]   write_ptr;
  logic [COPY_W-1:0]  copy_cnt;
  logic               copy_wr;
  logic               res_zero;
  logic [PTR_W-1:0]   res_fill;

  logic [FRAME_W-1:0] staging_mem [CHUNK_FRAMES];
  logic [FRAME_W-1:0] ring_mem [BUFFER_FRAMES];
  logic [FRAME_W-1:0] stage_q;
  logic [FRAME_W-1:0] ring_q;

  logic [PTR_W-1:0]   fill;
  logic [PTR_W-1:0]   read_ptr_inc;
  logic [PTR_W-1:0]   write_ptr_inc;
  logic               in_xfer;
  logic               stage_we;
  logic               ring_rd;
  logic signed [OUT_W-1:0] left_s16;
  logic signed [OUT_W-1:0] right_s16;

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;

  // Occupancy of the ring, with wrap for any ring depth.
  always_comb begin
    if (write_ptr >= read_ptr) begin
      fill = write_ptr - read_ptr;
    end else begin
      fill = PTR_W'(BUFFER_FRAMES - 32'(read_ptr) + 32'(write_ptr));
    end
    read_ptr_inc  = (read_ptr == PTR_LAST) ? '0 : read_ptr + 1'b1;
    write_ptr_inc = (write_ptr == PTR_LAST) ? '0 : write_ptr + 1'b1;
  end

  // A volume of zero drops the frame before it reaches staging.
  assign stage_we = in_xfer && (in_data.req_type == REQ_WRITE) && (volume != '0);
  // A buffered frame is popped only when not discarding, not paused and not empty.
  assign ring_rd  = in_xfer && (in_data.req_type == REQ_READ) && !discard && !pause &&
                    (fill != '0);

  // Staging chunk: written by write transfers, swept by the copy counter.
  always_ff @(posedge clk) begin
    if (stage_we) begin
      staging_mem[staging_count] <= {in_data.in_right, in_data.in_left};
    end
    stage_q <= staging_mem[copy_cnt[CHUNK_W-1:0]];
  end

  // Frame ring: the copy writes, a read transfer reads the oldest frame.
  always_ff @(posedge clk) begin
    if (copy_wr) begin
      ring_mem[write_ptr] <= stage_q;
    end
    if (ring_rd) begin
      ring_q <= ring_mem[read_ptr];
    end
  end

  afr_scale u_scale_left (
    .clk    (clk),
    .sample (ring_q[SAMPLE_W-1:0]),
    .volume (volume),
    .result (left_s16)
  );

  afr_scale u_scale_right (
    .clk    (clk),
    .sample (ring_q[FRAME_W-1:SAMPLE_W]),
    .volume (volume),
    .result (right_s16)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      volume        <= VOLUME_RESET;
      discard       <= 1'b0;
      pause         <= 1'b0;
      staging_count <= '0;
      read_ptr      <= '0;
      write_ptr     <= '0;
      copy_cnt      <= '0;
      copy_wr       <= 1'b0;
      out_valid     <= 1'b0;
      res_zero      <= 1'b1;
      res_fill      <= '0;
    end else begin
      copy_wr <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_VOLUME:  volume  <= VOL_W'(cfg_data);
          CFG_DISCARD: discard <= cfg_data[0];
          CFG_PAUSE:   pause   <= cfg_data[0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            unique case (in_data.req_type)
              REQ_WRITE: begin
                if (volume != '0) begin
                  if (staging_count == CHUNK_LAST) begin
                    // Full chunk: copy it only if it fits with room to spare.
                    staging_count <= '0;
                    if (!discard && (fill < PUSH_MAX)) begin
                      copy_cnt <= '0;
                      state    <= S_COPY;
                    end
                  end else begin
                    staging_count <= staging_count + 1'b1;
                  end
                end
              end
              REQ_FLUSH: begin
                staging_count <= '0;
                write_ptr     <= read_ptr;
              end
              REQ_READ: begin
                if (ring_rd) begin
                  res_zero <= 1'b0;
                  res_fill <= fill - 1'b1;
                  read_ptr <= read_ptr_inc;
                  state    <= S_FETCH;
                end else begin
                  // Zero fill; discard mode also reports an empty ring.
                  res_zero <= 1'b1;
                  res_fill <= discard ? '0 : fill;
                  state    <= S_OUT;
                end
              end
              default: ;
            endcase
          end
        end
        S_COPY: begin
          // The staging read issued for index k lands in stage_q and is
          // written to the ring from there while index k+1 is read.
          if (copy_wr) begin
            write_ptr <= write_ptr_inc;
          end
          if (copy_cnt == COPY_END) begin
            state <= S_IDLE;
          end else begin
            copy_wr  <= 1'b1;
            copy_cnt <= copy_cnt + 1'b1;
          end
        end
        S_FETCH: begin
          state <= S_MUL;
        end
        S_MUL: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid            <= 1'b1;
            out_data.out_left    <= res_zero ? '0 : left_s16;
            out_data.out_right   <= res_zero ? '0 : right_s16;
            out_data.from_buffer <= !res_zero;
            out_data.fill_level  <= FILL_W'(res_fill);
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/afr_scale.sv */
// Volume scaling and s16 conversion of one Q4.16 sample, two register stages.
// The result is valid once the sample and volume have passed both register stages
// and stays valid while they hold.
module afr_scale import afr_pkg::*; (
  input  logic                       clk,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic [VOL_W-1:0]           volume,
  output logic signed [OUT_W-1:0]    result
);

  // Full scale of sample * volume: 1.0 * 65536 * 100.
  localparam int PROD_W = SAMPLE_W + VOL_W + 1;
  localparam logic signed [PROD_W-1:0] UNITY = 28'sd6553600;
  localparam int M_W = 20;
  localparam int MAG_W = 23;
  // floor(2^20 / 25); the estimate it gives is low by at most one.
  localparam logic [15:0] RECIP25 = 16'd41943;

  logic signed [PROD_W-1:0] prod;
  logic [MAG_W-1:0]         mag;
  logic [MAG_W+15-1:0]      mag_pos;
  logic [M_W-1:0]           m_val;
  logic [M_W+16-1:0]        q_wide;
  logic                     neg, sat_lo, sat_hi;

  logic [M_W-1:0]           m_q;
  logic [OUT_W:0]           q0_q;
  logic                     neg_q, sat_lo_q, sat_hi_q;

  logic [M_W+1:0]           rem;
  logic [OUT_W:0]           q_fix;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(sample) * PROD_W'($signed({1'b0, volume}));
  end

  always_comb begin
    neg     = prod[PROD_W-1];
    sat_lo  = (prod <= -UNITY);
    sat_hi  = (prod >= UNITY);
    mag     = neg ? MAG_W'(-prod) : MAG_W'(prod);
    // Positive side: p * 32767 / 6553600 = ((p * 32767) >> 18) / 25.
    // Negative side: |p| * 32768 / 6553600 = (|p| >> 3) / 25.
    mag_pos = ({mag, 15'd0}) - (MAG_W+15)'(mag);
    m_val   = neg ? M_W'(mag >> 3) : M_W'(mag_pos >> 18);
    q_wide  = m_val * RECIP25;
  end

  always_ff @(posedge clk) begin
    m_q      <= m_val;
    q0_q     <= (OUT_W+1)'(q_wide >> 20);
    neg_q    <= neg;
    sat_lo_q <= sat_lo;
    sat_hi_q <= sat_hi;
  end

  always_comb begin
    rem   = (M_W+2)'(m_q) - ((M_W+2)'(q0_q) * (M_W+2)'(25));
    q_fix = (rem >= (M_W+2)'(25)) ? q0_q + 1'b1 : q0_q;
    if (sat_lo_q) begin
      result = 16'sh8000;
    end else if (sat_hi_q) begin
      result = 16'sh7fff;
    end else if (neg_q) begin
      result = -$signed(OUT_W'(q_fix));
    end else begin
      result = $signed(OUT_W'(q_fix));
    end
  end

endmodule
